// ===== src/seedr_pkg.sv =====
// seedr_pkg: shared types, constants and state codes of the seed text resolver
// no dependencies
`timescale 1ns / 1ps

package seedr_pkg;

  localparam int MAX_TEXT_LEN_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [63:0] GOLDEN    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B     = 64'h94D049BB133111EB;
  localparam logic [63:0] FNV_BASE  = 64'hCBF29CE484222325;
  localparam logic [8:0]  FNV_LOW   = 9'h1B3;
  localparam logic [63:0] MAG_NEG_MAX = 64'h8000000000000000;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_END    = 1'b1;

  localparam logic [1:0] SRC_CLOCK    = 2'd0;
  localparam logic [1:0] SRC_SIGNED   = 2'd1;
  localparam logic [1:0] SRC_UNSIGNED = 2'd2;
  localparam logic [1:0] SRC_HASH     = 2'd3;

  typedef struct packed {
    logic       minus;
    logic       digit;
    logic       blank;
    logic [7:0] ch;
  } text_word_t;

  typedef struct packed {
    logic        mode;
    text_word_t  word;
    logic [63:0] ticks;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PARSE,
    ST_DECIDE,
    ST_MUL_A,
    ST_MUL_B,
    ST_OUT
  } back_state_t;

endpackage

// ===== src/seedr_ram.sv =====
// seedr_ram: generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module seedr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/seedr_front.sv =====
// seedr_front: accepts input items, classifies the text byte, queues items
// depends on seedr_pkg
`timescale 1ns / 1ps

module seedr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  pop,
  output seedr_pkg::queue_head_t head
);

  localparam int CW = $clog2(seedr_pkg::QUEUE_DEPTH + 1);
  localparam int PW = seedr_pkg::QUEUE_DEPTH > 1 ? $clog2(seedr_pkg::QUEUE_DEPTH) : 1;

  seedr_pkg::item_t slot_r [seedr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  seedr_pkg::item_t new_item;
  logic [7:0] ch;
  logic push, take;

  assign ch = in_tdata[7:0];
  assign in_tready = cnt_r != CW'(seedr_pkg::QUEUE_DEPTH);
  assign push = in_tvalid && in_tready;
  assign take = pop && cnt_r != '0;

  always_comb begin
    new_item.mode       = in_tuser[0];
    new_item.word.ch    = ch;
    new_item.word.blank = ch == seedr_pkg::CH_SPACE || ch == seedr_pkg::CH_TAB ||
                          ch == seedr_pkg::CH_CR || ch == seedr_pkg::CH_LF;
    new_item.word.digit = ch >= seedr_pkg::CH_ZERO && ch <= seedr_pkg::CH_NINE;
    new_item.word.minus = ch == seedr_pkg::CH_MINUS;
    new_item.ticks      = in_tdata[71:8];
  end

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(seedr_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (take) begin
      rp_nxt = (rp_r == PW'(seedr_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !take) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (take && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= new_item;
    end
  end

  assign head.vld  = cnt_r != '0;
  assign head.item = slot_r[rp_r];

endmodule

// ===== src/seedr_back.sv =====
// seedr_back: text store, trimming, decimal parse, fnv-1a hash and mix finalizer
// depends on seedr_pkg and seedr_ram
`timescale 1ns / 1ps

module seedr_back #(
  parameter int MAX_TEXT_LEN = seedr_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  seedr_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,
  output logic [2:0]            out_tuser
);

  localparam int LW = $clog2(MAX_TEXT_LEN + 1);
  localparam int AW = MAX_TEXT_LEN > 1 ? $clog2(MAX_TEXT_LEN) : 1;
  localparam int WW = $bits(seedr_pkg::text_word_t);

  function automatic logic [63:0] premix(input logic [63:0] v);
    logic [63:0] z;
    z = v + seedr_pkg::GOLDEN;
    return z ^ (z >> 30);
  endfunction

  seedr_pkg::back_state_t st_r, st_nxt;
  logic [LW-1:0] len_r, len_nxt, lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [LW-1:0] iss_idx_r, iss_idx_nxt;
  logic iss_r, iss_nxt, ovf_r, ovf_nxt, found_r, found_nxt;
  logic neg_r, neg_nxt, ok_r, ok_nxt, big_r, big_nxt, ndig_r, ndig_nxt;
  logic trunc_r, trunc_nxt;
  logic [63:0] mag_r, mag_nxt, h_r, h_nxt, mop_r, mop_nxt;
  logic [63:0] prod_r, prod_nxt, acc_r, acc_nxt, seed_r, seed_nxt;
  logic [1:0] mc_r, mc_nxt, src_r, src_nxt;
  logic ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic [2:0] ou_r, ou_nxt;

  logic we, rd_en;
  logic [WW-1:0] rdata;
  seedr_pkg::text_word_t w;
  logic [67:0] mag10;
  logic [63:0] hx, fin, mconst, mul_tmp;
  logic [72:0] hlow;
  logic [31:0] ma, mb;

  assign w = seedr_pkg::text_word_t'(rdata);

  seedr_ram #(.WIDTH(WW), .DEPTH(MAX_TEXT_LEN)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (len_r[AW-1:0]),
    .wdata (WW'(head.item.word)),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    mag10 = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {64'd0, w.ch[3:0]};
    hx    = h_r ^ {56'd0, w.ch};
    hlow  = hx * seedr_pkg::FNV_LOW;
    mconst = (st_r == seedr_pkg::ST_MUL_B) ? seedr_pkg::MIX_B : seedr_pkg::MIX_A;
    fin   = acc_r + {prod_r[31:0], 32'd0};
    unique case (mc_r)
      2'd0:    begin ma = mop_r[31:0];  mb = mconst[31:0];  end
      2'd1:    begin ma = mop_r[31:0];  mb = mconst[63:32]; end
      default: begin ma = mop_r[63:32]; mb = mconst[31:0];  end
    endcase
    mul_tmp = ma * mb;
  end

  always_comb begin
    st_nxt = st_r;
    len_nxt = len_r; lo_nxt = lo_r; hi_nxt = hi_r; idx_nxt = idx_r;
    iss_nxt = 1'b0; iss_idx_nxt = idx_r;
    ovf_nxt = ovf_r; found_nxt = found_r; trunc_nxt = trunc_r;
    neg_nxt = neg_r; ok_nxt = ok_r; big_nxt = big_r; ndig_nxt = ndig_r;
    mag_nxt = mag_r; h_nxt = h_r; mop_nxt = mop_r;
    prod_nxt = prod_r; acc_nxt = acc_r; seed_nxt = seed_r;
    mc_nxt = mc_r; src_nxt = src_r;
    ov_nxt = ov_r && !out_tready; od_nxt = od_r; ou_nxt = ou_r;
    pop = 1'b0; we = 1'b0; rd_en = 1'b0;
    unique case (st_r)
      seedr_pkg::ST_IDLE: begin
        if (head.vld) begin
          pop = 1'b1;
          if (head.item.mode == seedr_pkg::MODE_APPEND) begin
            if (len_r < LW'(MAX_TEXT_LEN)) begin
              we = 1'b1;
              len_nxt = len_r + LW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            mop_nxt = premix(head.item.ticks);
            trunc_nxt = ovf_r;
            idx_nxt = '0;
            found_nxt = 1'b0;
            st_nxt = seedr_pkg::ST_SCAN;
          end
        end
      end
      seedr_pkg::ST_SCAN: begin
        rd_en = idx_r < len_r;
        if (rd_en) idx_nxt = idx_r + LW'(1);
        iss_nxt = rd_en;
        if (iss_r && !w.blank) begin
          if (!found_r) begin
            found_nxt = 1'b1;
            lo_nxt = iss_idx_r;
          end
          hi_nxt = iss_idx_r + LW'(1);
        end
        if (!rd_en && !iss_r) begin
          mc_nxt = 2'd0;
          if (!found_r) begin
            src_nxt = seedr_pkg::SRC_CLOCK;
            st_nxt = seedr_pkg::ST_MUL_A;
          end else begin
            idx_nxt = lo_r;
            neg_nxt = 1'b0; ok_nxt = 1'b1; big_nxt = 1'b0; ndig_nxt = 1'b0;
            mag_nxt = '0;
            h_nxt = seedr_pkg::FNV_BASE;
            st_nxt = seedr_pkg::ST_PARSE;
          end
        end
      end
      seedr_pkg::ST_PARSE: begin
        rd_en = idx_r < hi_r;
        if (rd_en) idx_nxt = idx_r + LW'(1);
        iss_nxt = rd_en;
        if (iss_r) begin
          h_nxt = {hx[23:0], 40'd0} + hlow[63:0];
          if (iss_idx_r == lo_r && w.minus) begin
            neg_nxt = 1'b1;
          end else if (w.digit) begin
            ndig_nxt = 1'b1;
            mag_nxt = mag10[63:0];
            big_nxt = big_r || (|mag10[67:64]);
          end else begin
            ok_nxt = 1'b0;
          end
        end
        if (!rd_en && !iss_r) st_nxt = seedr_pkg::ST_DECIDE;
      end
      seedr_pkg::ST_DECIDE: begin
        mc_nxt = 2'd0;
        if (ok_r && ndig_r && !big_r && neg_r && mag_r <= seedr_pkg::MAG_NEG_MAX) begin
          seed_nxt = 64'd0 - mag_r;
          src_nxt = seedr_pkg::SRC_SIGNED;
          st_nxt = seedr_pkg::ST_OUT;
        end else if (ok_r && ndig_r && !big_r && !neg_r) begin
          seed_nxt = mag_r;
          src_nxt = mag_r[63] ? seedr_pkg::SRC_UNSIGNED : seedr_pkg::SRC_SIGNED;
          st_nxt = seedr_pkg::ST_OUT;
        end else begin
          mop_nxt = premix(h_r);
          src_nxt = seedr_pkg::SRC_HASH;
          st_nxt = seedr_pkg::ST_MUL_A;
        end
      end
      seedr_pkg::ST_MUL_A, seedr_pkg::ST_MUL_B: begin
        prod_nxt = mul_tmp;
        mc_nxt = mc_r + 2'd1;
        unique case (mc_r)
          2'd0: ;
          2'd1: acc_nxt = prod_r;
          2'd2: acc_nxt = fin;
          default: begin
            mc_nxt = 2'd0;
            if (st_r == seedr_pkg::ST_MUL_A) begin
              mop_nxt = fin ^ (fin >> 27);
              st_nxt = seedr_pkg::ST_MUL_B;
            end else begin
              seed_nxt = ((fin ^ (fin >> 31)) == 64'd0) ? seedr_pkg::GOLDEN
                                                        : (fin ^ (fin >> 31));
              st_nxt = seedr_pkg::ST_OUT;
            end
          end
        endcase
      end
      seedr_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = seed_r;
          ou_nxt = {trunc_r, src_r};
          len_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt = seedr_pkg::ST_IDLE;
        end
      end
      default: st_nxt = seedr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= seedr_pkg::ST_IDLE;
      len_r <= '0;
      ovf_r <= 1'b0;
      iss_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      iss_r <= iss_nxt;
      ov_r  <= ov_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt; iss_idx_r <= iss_idx_nxt;
    found_r <= found_nxt; trunc_r <= trunc_nxt;
    neg_r <= neg_nxt; ok_r <= ok_nxt; big_r <= big_nxt; ndig_r <= ndig_nxt;
    mag_r <= mag_nxt; h_r <= h_nxt; mop_r <= mop_nxt;
    prod_r <= prod_nxt; acc_r <= acc_nxt; seed_r <= seed_nxt;
    mc_r <= mc_nxt; src_r <= src_nxt;
    od_r <= od_nxt; ou_r <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_TEXT_LEN))
    else $error("text length past store size");

  a_hash_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (ou_r[1:0] == seedr_pkg::SRC_CLOCK || ou_r[1:0] == seedr_pkg::SRC_HASH)
    |-> od_r != 64'd0)
    else $error("zero seed on mixed path");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == seedr_pkg::ST_IDLE |-> !iss_r)
    else $error("store read pending while idle");

  a_len_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == seedr_pkg::ST_OUT && st_nxt == seedr_pkg::ST_IDLE |=> len_r == '0 && !ovf_r)
    else $error("store not emptied after result");

endmodule

// ===== src/seed_text_resolver.sv =====
// seed_text_resolver: top level, joins the input front end and the resolving back end
// depends on seedr_pkg, seedr_front, seedr_back
`timescale 1ns / 1ps

// in channel: in_tuser[0] mode (0 append byte, 1 end text), in_tdata text byte and
//   clock ticks; end items produce one result, append items none
// out channel: out_tdata seed, out_tuser source and truncated flag
// a two-item queue sits between the front end and the back end, so input is taken
//   while the back end works or a result waits
// append items: one per cycle through the back end while it is idle
// end item: a store scan over the text, then a parse of the trimmed span (one
//   store read port, one byte a cycle); clock and hash sources then take the two
//   64-bit mix multiplies, each built from three 32x32 products on one multiplier
// result held in an output register until out_tready; the back end stalls in
//   its last state and the queue fills, then in_tready drops
// reset clears length, overflow flag, queue and output valid; store contents
//   need no clearing
module seed_text_resolver #(
  parameter int MAX_TEXT_LEN = seedr_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // text_byte, clock_ticks
  input  logic [0:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // seed
  output logic [2:0]  out_tuser   // source, truncated
);

  seedr_pkg::queue_head_t head;
  logic pop;

  seedr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .pop       (pop),
    .head      (head)
  );

  seedr_back #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
